// File: design/sps_pkg.sv
`timescale 1ns / 1ps

package sps_pkg;

  // Geometry of the pattern. The cell address is {track, step}, so STEPS
  // must stay equal to 2**STEP_W.
  localparam int TRACKS = 8;
  localparam int STEPS  = 64;
  localparam int TRK_W  = 3;
  localparam int STEP_W = 6;
  localparam int CELLS  = TRACKS * STEPS;
  localparam int ADDR_W = TRK_W + STEP_W;
  localparam int CNT_W  = ADDR_W + 1;

  localparam int VEL_W = 7;
  localparam int OFF_W = 5;
  localparam int LEN_W = 7;
  localparam int DIV_W = 3;
  localparam int LIM_W = 4;

  localparam int MAX_VELOCITY      = 127;
  localparam int MIN_LENGTH        = 1;
  localparam int DEFAULT_LENGTH    = 16;
  localparam int DEFAULT_VEL_RESET = 100;
  localparam int DIV_COUNT         = 6;
  localparam int DIV_RESET         = 3;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // Ticks per step for each grid division.
  localparam logic [4:0] TICKS [DIV_COUNT] = '{5'd24, 5'd12, 5'd8, 5'd6, 5'd4, 5'd3};

  localparam logic [2:0] MODE_SET      = 3'd0;
  localparam logic [2:0] MODE_CLEAR    = 3'd1;
  localparam logic [2:0] MODE_TOGGLE   = 3'd2;
  localparam logic [2:0] MODE_READ     = 3'd3;
  localparam logic [2:0] MODE_SET_LEN  = 3'd4;
  localparam logic [2:0] MODE_SET_DIV  = 3'd5;
  localparam logic [2:0] MODE_QUERY    = 3'd6;
  localparam logic [2:0] MODE_NOP      = 3'd7;

  typedef struct packed {
    logic [VEL_W-1:0]        vel;
    logic signed [OFF_W-1:0] off;
  } entry_t;

  function automatic logic [LIM_W-1:0] off_limit(input logic [DIV_W-1:0] div);
    logic [4:0] ticks;
    logic [4:0] half;
    ticks = (div < DIV_W'(DIV_COUNT)) ? TICKS[div] : TICKS[DIV_RESET];
    half  = (ticks - 5'd1) >> 1;
    return half[LIM_W-1:0];
  endfunction

  function automatic logic signed [OFF_W-1:0] clamp_off(input logic signed [7:0] v,
                                                        input logic [LIM_W-1:0] lim);
    logic signed [7:0] hi;
    logic signed [7:0] lo;
    logic signed [7:0] r;
    hi = signed'(8'(lim));
    lo = -hi;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[OFF_W-1:0];
  endfunction

  function automatic logic [VEL_W-1:0] clamp_vel(input logic [7:0] v);
    return (v > 8'(MAX_VELOCITY)) ? VEL_W'(MAX_VELOCITY) : v[VEL_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] clamp_len(input logic [7:0] v);
    logic [LEN_W-1:0] r;
    if (v < 8'(MIN_LENGTH)) begin
      r = LEN_W'(MIN_LENGTH);
    end else if (v > 8'(STEPS)) begin
      r = LEN_W'(STEPS);
    end else begin
      r = v[LEN_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [DIV_W-1:0] clamp_div(input logic [DIV_W-1:0] v);
    return (v > DIV_W'(DIV_COUNT - 1)) ? DIV_W'(DIV_COUNT - 1) : v;
  endfunction

endpackage

// File: design/step_pattern_store.sv
`timescale 1ns / 1ps
// Step-sequencer pattern store. Operations arrive on the in_ stream (mode in
// in_tuser, arguments in in_tdata) and each one yields exactly one result
// transfer on the out_ stream. The default toggle velocity is written through
// the cfg_ channel, which is always ready and should only be used while idle.
// Velocity and offset of every cell live in one synchronous memory of
// TRACKS*STEPS entries, updated by read, modify and write back.
// Set, clear, toggle, read and set length pass from the input transfer through
// the memory read, the execute state and the put state to the output register;
// no new item is taken until the block is back in idle.
// Set division and song query sweep the whole memory, one cell a cycle, since
// the memory has a single read port; no new item is taken during the sweep.
// After reset a clearing pass writes every cell to zero, one per cycle; no
// item is accepted during it, but configuration is.
// The result sits in an output register, so an item may be accepted while the
// previous result waits; a stalled receiver holds the pipeline only once the
// next result is ready to be handed over.
module step_pattern_store
  import sps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // track[2:0], step[8:3], velocity[16:9], offset[24:17],
  // length_value[32:25], division_value[35:33], zero padding above
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // mode[2:0]
  input  logic [2:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // velocity_out[6:0], offset_out[11:7], step_on[12], max_track_len[19:13],
  // song_empty[20], zero padding above
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // ignored[0]
  output logic                   out_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [VEL_W-1:0]       cfg_data
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;

  entry_t mem [CELLS];

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  grid_r, grid_nxt;
  logic [LEN_W-1:0]  len_r [TRACKS];
  logic [LEN_W-1:0]  len_nxt [TRACKS];
  logic [VEL_W-1:0]  dv_r;
  logic [LEN_W-1:0]  longest_r, longest_nxt;
  logic              empty_r, empty_nxt;
  entry_t            res_r, res_nxt;
  logic              ign_r, ign_nxt;
  logic              wk_vld_r, wk_vld_nxt;
  logic [ADDR_W-1:0] wk_addr_r, wk_addr_nxt;
  entry_t            rd_data_r;
  logic              out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic              out_ign_r;

  logic [2:0]        it_mode_r;
  logic [TRK_W-1:0]  it_trk_r;
  logic [STEP_W-1:0] it_step_r;
  logic [7:0]        it_vel_r;
  logic signed [7:0] it_off_r;
  logic [7:0]        it_len_r;
  logic [DIV_W-1:0]  it_div_r;

  logic [TRK_W-1:0]  in_trk;
  logic [STEP_W-1:0] in_step;
  logic              accept;
  logic              it_trk_ok;
  logic              it_addr_ok;
  logic [ADDR_W-1:0] it_cell;
  logic [ADDR_W-1:0] in_cell;
  logic [LIM_W-1:0]  cur_lim;
  entry_t            new_ent;
  entry_t            walk_ent;
  logic              ign_calc;
  logic [LEN_W-1:0]  wk_len;
  logic              wk_in_len;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;
  logic              out_load;
  logic [LEN_W-1:0]  put_slen;
  logic              put_sempty;

  assign in_trk  = in_tdata[2:0];
  assign in_step = in_tdata[8:3];
  assign accept  = in_tvalid && in_tready;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  assign it_trk_ok  = {1'b0, it_trk_r} < (TRK_W + 1)'(TRACKS);
  assign it_addr_ok = it_trk_ok && ({1'b0, it_step_r} < (STEP_W + 1)'(STEPS));
  assign it_cell    = it_addr_ok ? {it_trk_r, it_step_r} : '0;
  assign in_cell    = {in_trk, in_step};
  assign cur_lim    = off_limit(grid_r);

  // Entry after a single-cell operation, built from the old contents.
  always_comb begin
    new_ent = rd_data_r;
    unique case (it_mode_r)
      MODE_SET: begin
        new_ent.vel = clamp_vel(it_vel_r);
        new_ent.off = clamp_off(it_off_r, cur_lim);
      end
      MODE_CLEAR: begin
        new_ent = '0;
      end
      MODE_TOGGLE: begin
        if (rd_data_r.vel != '0) begin
          new_ent = '0;
        end else begin
          new_ent.vel = clamp_vel({1'b0, dv_r});
          new_ent.off = '0;
        end
      end
      default: begin
        new_ent = rd_data_r;
      end
    endcase
  end

  always_comb begin
    unique case (it_mode_r)
      MODE_SET_LEN:             ign_calc = !it_trk_ok;
      MODE_SET_DIV, MODE_QUERY: ign_calc = 1'b0;
      default:                  ign_calc = !it_addr_ok;
    endcase
  end

  // During the sweep the division limit has already been updated.
  always_comb begin
    walk_ent = rd_data_r;
    if (it_mode_r == MODE_SET_DIV) begin
      walk_ent.off = clamp_off({{(8 - OFF_W){rd_data_r.off[OFF_W-1]}}, rd_data_r.off},
                               cur_lim);
    end
  end

  assign wk_len    = len_r[wk_addr_r[ADDR_W-1:STEP_W]];
  assign wk_in_len = {1'b0, wk_addr_r[STEP_W-1:0]} < wk_len;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    grid_nxt    = grid_r;
    len_nxt     = len_r;
    longest_nxt = longest_r;
    empty_nxt   = empty_r;
    res_nxt     = res_r;
    ign_nxt     = ign_r;
    wk_vld_nxt  = 1'b0;
    wk_addr_nxt = wk_addr_r;
    rd_en       = 1'b0;
    rd_addr     = in_cell;
    wr_en       = 1'b0;
    wr_addr     = it_cell;
    wr_data     = new_ent;
    out_load    = 1'b0;
    unique case (state_r)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r[ADDR_W-1:0];
        wr_data = '0;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          rd_en     = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt     = it_addr_ok ? new_ent : '0;
        ign_nxt     = ign_calc;
        cnt_nxt     = '0;
        longest_nxt = LEN_W'(MIN_LENGTH);
        empty_nxt   = 1'b1;
        if (it_addr_ok && (it_mode_r == MODE_SET || it_mode_r == MODE_CLEAR ||
                           it_mode_r == MODE_TOGGLE)) begin
          wr_en = 1'b1;
        end
        if (it_mode_r == MODE_SET_LEN && it_trk_ok) begin
          len_nxt[it_trk_r] = clamp_len(it_len_r);
        end
        if (it_mode_r == MODE_SET_DIV) begin
          grid_nxt = clamp_div(it_div_r);
        end
        if (it_mode_r == MODE_SET_DIV || it_mode_r == MODE_QUERY) begin
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_WALK: begin
        // Read cell n while cell n-1 is checked and, for a division change,
        // written back; the two addresses never coincide.
        if (cnt_r < CNT_W'(CELLS)) begin
          rd_en       = 1'b1;
          rd_addr     = cnt_r[ADDR_W-1:0];
          cnt_nxt     = cnt_r + 1'b1;
          wk_vld_nxt  = 1'b1;
          wk_addr_nxt = cnt_r[ADDR_W-1:0];
        end
        if (wk_vld_r) begin
          if (it_mode_r == MODE_SET_DIV) begin
            wr_en   = 1'b1;
            wr_addr = wk_addr_r;
            wr_data = walk_ent;
          end
          if (it_addr_ok && wk_addr_r == it_cell) begin
            res_nxt = walk_ent;
          end
          if (wk_len > longest_r) begin
            longest_nxt = wk_len;
          end
          if (wk_in_len && rd_data_r.vel != '0) begin
            empty_nxt = 1'b0;
          end
          if (wk_addr_r == ADDR_W'(CELLS - 1)) begin
            state_nxt = S_PUT;
          end
        end
      end
      S_PUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign put_slen   = (it_mode_r == MODE_QUERY) ? longest_r : '0;
  assign put_sempty = (it_mode_r == MODE_QUERY) ? empty_r : 1'b0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      grid_r      <= DIV_W'(DIV_RESET);
      dv_r        <= VEL_W'(DEFAULT_VEL_RESET);
      wk_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int t = 0; t < TRACKS; t++) begin
        len_r[t] <= LEN_W'(DEFAULT_LENGTH);
      end
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      grid_r   <= grid_nxt;
      wk_vld_r <= wk_vld_nxt;
      len_r    <= len_nxt;
      if (cfg_valid && cfg_ready) begin
        dv_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    longest_r <= longest_nxt;
    empty_r   <= empty_nxt;
    res_r     <= res_nxt;
    ign_r     <= ign_nxt;
    wk_addr_r <= wk_addr_nxt;
    if (accept) begin
      it_mode_r <= in_tuser;
      it_trk_r  <= in_trk;
      it_step_r <= in_step;
      it_vel_r  <= in_tdata[16:9];
      it_off_r  <= in_tdata[24:17];
      it_len_r  <= in_tdata[32:25];
      it_div_r  <= in_tdata[35:33];
    end
    if (out_load) begin
      out_data_r <= {3'b000, put_sempty, put_slen, (res_r.vel != '0), res_r.off, res_r.vel};
      out_ign_r  <= ign_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ign_r;

endmodule

// File: design/sps_checker.sv
`timescale 1ns / 1ps
module sps_checker
  import sps_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // A result held back by the receiver must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_step_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[12] == (out_tdata[6:0] != 7'd0)))
    else $error("step_on disagrees with velocity");

  a_song_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[19:13] <= 7'(STEPS)))
    else $error("song length beyond step count");

  // Offsets never exceed the widest division limit of eleven ticks.
  a_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[11:7] < 5'd12 || out_tdata[11:7] > 5'd20))
    else $error("offset outside division limit");

  // Reset starts the clearing pass, so no transfer is possible right after it.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("channel active straight after reset");

endmodule

bind step_pattern_store sps_checker u_sps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
